### design/mtep_pkg.sv
// Shared types and constants for the MIDI track event parser.
package mtep_pkg;

  localparam logic [7:0] STATUS_META  = 8'hFF;
  localparam logic [7:0] STATUS_MIN   = 8'h80;
  localparam logic [7:0] STATUS_MAX   = 8'hEF;
  localparam logic [3:0] CMD_PROGRAM  = 4'hC;
  localparam logic [3:0] CMD_PRESSURE = 4'hD;
  localparam logic [7:0] META_SEQNUM  = 8'h00;
  localparam logic [7:0] META_TEXT_LO = 8'h01;
  localparam logic [7:0] META_TEXT_HI = 8'h07;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_TIMESIG = 8'h58;

  typedef enum logic [3:0] {
    PH_DELTA  = 4'd0,
    PH_STATUS = 4'd1,
    PH_DATA1  = 4'd2,
    PH_DATA2  = 4'd3,
    PH_MTYPE  = 4'd4,
    PH_MLEN   = 4'd5,
    PH_MBODY  = 4'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_CHANNEL = 3'd0,
    KIND_TEXT    = 3'd1,
    KIND_EOT     = 3'd2,
    KIND_TEMPO   = 3'd3,
    KIND_TIMESIG = 3'd4,
    KIND_UNKNOWN = 3'd5,
    KIND_ERROR   = 3'd6
  } event_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] event_tick;
    logic [7:0]  code;
    logic [3:0]  channel;
    logic [7:0]  value_a;
    logic [7:0]  value_b;
    logic [7:0]  value_c;
    logic [7:0]  value_d;
    logic [23:0] tempo;
    logic [31:0] meta_length;
  } out_item_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] vlq;
    logic [31:0] tick;
    logic [7:0]  run_status;
    logic [7:0]  meta_type;
    logic [31:0] remaining;
    logic [23:0] payload;
    logic        halted;
  } parse_state_t;

endpackage

### design/midi_track_event_parser.sv
// Top level of the MIDI track event parser: input register, parser state and result register.
//
//   Channel  Direction  Handshake              Carries
//   in_      input      in_valid / in_stall    one track body byte and its track-start mark
//   out_     output     out_valid / out_stall  one decoded event record
//
// One byte is taken every cycle while the result side keeps up; a byte
// waits in the input register, and any record it completes is loaded into
// the result register straight from the combinational byte decoder.
// The rate is set by the single pass through the byte decoder, whose widest
// path is the 32-bit tick addition and the meta payload index subtraction.
// Synchronous active-low reset clears the parser state and both valid flags.
// A stalled result holds the input register, which in turn raises in_stall.
module midi_track_event_parser
  import mtep_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Input register: the byte waiting to be decoded.
  logic         in_q_valid_r, in_q_valid_nxt;
  in_item_t     in_q_r;

  // Parser state, updated once for every byte that passes the decoder.
  parse_state_t state_r, state_nxt;

  logic         advance;
  logic         accept;
  logic         rec_valid;
  out_item_t    rec;

  // A byte moves through the decoder when the result register is empty or is
  // being emptied in this cycle, so no record is ever overwritten.
  assign advance  = in_q_valid_r && (!out_valid || !out_stall);
  assign in_stall = in_q_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_q_valid_nxt = in_q_valid_r;
    if (accept) begin
      in_q_valid_nxt = 1'b1;
    end else if (advance) begin
      in_q_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_valid_r <= 1'b0;
    end else begin
      in_q_valid_r <= in_q_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q_r <= in_data;
    end
  end

  mtep_decode u_decode (
    .state_i     (state_r),
    .item_i      (in_q_r),
    .state_o     (state_nxt),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  // The whole state is cleared at reset; it only moves when a byte is decoded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_DELTA, default: '0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  mtep_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (advance && rec_valid),
    .rec_i     (rec),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A halted parser produces nothing until a track start arrives.
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    advance && state_r.halted && !in_q_r.track_start |-> !rec_valid)
    else $error("record produced while halted");

  // An error record always leaves the parser halted.
  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    advance && rec_valid && rec.event_kind == KIND_ERROR |=> state_r.halted)
    else $error("error record without halt");

  // A decoded record always lands in the result register.
  a_record_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    advance && rec_valid |=> out_valid)
    else $error("decoded record lost");

  // While a held result blocks the decoder, the waiting byte is held back too.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_q_valid_r && out_valid && out_stall |-> in_stall && !advance)
    else $error("decoder advanced into a full result register");

endmodule

### design/mtep_decode.sv
// Combinational byte decoder: next parser state and the record a byte produces.
module mtep_decode
  import mtep_pkg::*;
(
  input  parse_state_t state_i,
  input  in_item_t     item_i,
  output parse_state_t state_o,
  output logic         rec_valid_o,
  output out_item_t    rec_o
);

  function automatic out_item_t chan_rec(logic [31:0] tick, logic [7:0] st,
                                         logic [7:0] a, logic [7:0] b);
    out_item_t r;
    r            = '0;
    r.event_kind = KIND_CHANNEL;
    r.event_tick = tick;
    r.code       = {st[7:4], 4'h0};
    r.channel    = st[3:0];
    r.value_a    = a;
    r.value_b    = b;
    return r;
  endfunction

  function automatic out_item_t meta_rec(logic [31:0] tick, logic [7:0] mtype,
                                         logic [23:0] pay, logic [7:0] fourth,
                                         logic [31:0] len);
    out_item_t r;
    r            = '0;
    r.event_tick = tick;
    r.code       = mtype;
    r.meta_length = len;
    if (mtype >= META_TEXT_LO && mtype <= META_TEXT_HI) begin
      r.event_kind = KIND_TEXT;
    end else if (mtype == META_EOT) begin
      r.event_kind = KIND_EOT;
    end else if (mtype == META_TEMPO) begin
      r.event_kind = KIND_TEMPO;
      r.tempo      = pay;
    end else if (mtype == META_TIMESIG) begin
      r.event_kind = KIND_TIMESIG;
      r.value_a    = pay[7:0];
      r.value_b    = pay[15:8];
      r.value_c    = pay[23:16];
      r.value_d    = fourth;
    end else begin
      r.event_kind = KIND_UNKNOWN;
    end
    return r;
  endfunction

  parse_state_t cur;
  logic [7:0]   b;
  logic [31:0]  vlq_shift;
  logic [7:0]   eff_st;
  logic [31:0]  idx;
  logic [31:0]  rem_dec;
  logic         last;
  logic [23:0]  pay_new;
  logic         is_chan;
  logic         short_cmd;

  always_comb begin
    cur = state_i;
    if (item_i.track_start) begin
      cur.tick      = '0;
      cur.halted    = 1'b0;
      cur.phase     = PH_DELTA;
      cur.vlq       = '0;
      cur.remaining = '0;
      cur.payload   = '0;
    end
    b         = item_i.data_byte;
    vlq_shift = {cur.vlq[24:0], b[6:0]};
    eff_st    = b[7] ? b : cur.run_status;
    is_chan   = (eff_st >= STATUS_MIN) && (eff_st <= STATUS_MAX);
    short_cmd = (cur.run_status[7:4] == CMD_PROGRAM) || (cur.run_status[7:4] == CMD_PRESSURE);
    idx       = cur.vlq - cur.remaining;
    rem_dec   = cur.remaining - 32'd1;
    last      = (rem_dec == '0);
    pay_new   = cur.payload;
    state_o   = cur;
    rec_valid_o = 1'b0;
    rec_o       = '0;

    if (!cur.halted) begin
      unique case (cur.phase)
        PH_DELTA: begin
          state_o.vlq = vlq_shift;
          if (!b[7]) begin
            state_o.tick  = cur.tick + vlq_shift;
            state_o.vlq   = '0;
            state_o.phase = PH_STATUS;
          end
        end
        PH_STATUS: begin
          state_o.run_status = eff_st;
          if (eff_st == STATUS_META) begin
            if (b[7]) begin
              state_o.phase = PH_MTYPE;
            end else begin
              state_o.meta_type = b;
              state_o.vlq       = '0;
              state_o.phase     = PH_MLEN;
            end
          end else if (is_chan) begin
            if (b[7]) begin
              state_o.phase = PH_DATA1;
            end else if ((eff_st[7:4] == CMD_PROGRAM) || (eff_st[7:4] == CMD_PRESSURE)) begin
              rec_valid_o   = 1'b1;
              rec_o         = chan_rec(cur.tick, eff_st, b, 8'h00);
              state_o.phase = PH_DELTA;
            end else begin
              state_o.payload = {16'h0000, b};
              state_o.phase   = PH_DATA2;
            end
          end else begin
            rec_valid_o      = 1'b1;
            rec_o            = '0;
            rec_o.event_kind = KIND_ERROR;
            rec_o.event_tick = cur.tick;
            rec_o.code       = eff_st;
            state_o.halted   = 1'b1;
            state_o.phase    = PH_DELTA;
          end
        end
        PH_DATA1: begin
          if (short_cmd) begin
            rec_valid_o   = 1'b1;
            rec_o         = chan_rec(cur.tick, cur.run_status, b, 8'h00);
            state_o.phase = PH_DELTA;
          end else begin
            state_o.payload = {16'h0000, b};
            state_o.phase   = PH_DATA2;
          end
        end
        PH_DATA2: begin
          rec_valid_o   = 1'b1;
          rec_o         = chan_rec(cur.tick, cur.run_status, cur.payload[7:0], b);
          state_o.phase = PH_DELTA;
        end
        PH_MTYPE: begin
          state_o.meta_type = b;
          state_o.vlq       = '0;
          state_o.phase     = PH_MLEN;
        end
        PH_MLEN: begin
          state_o.vlq = vlq_shift;
          if (!b[7]) begin
            state_o.remaining = vlq_shift;
            state_o.payload   = '0;
            if (vlq_shift == '0) begin
              rec_valid_o   = (cur.meta_type != META_SEQNUM);
              rec_o         = meta_rec(cur.tick, cur.meta_type, 24'h0, 8'h00, vlq_shift);
              state_o.phase = PH_DELTA;
            end else begin
              state_o.phase = PH_MBODY;
            end
          end
        end
        PH_MBODY: begin
          state_o.remaining = rem_dec;
          if (cur.meta_type == META_TEMPO) begin
            if (idx < 32'd3) begin
              pay_new         = {cur.payload[15:0], b};
              state_o.payload = pay_new;
              if (idx == 32'd2 || last) begin
                rec_valid_o = 1'b1;
                rec_o       = meta_rec(cur.tick, cur.meta_type, pay_new, 8'h00, cur.vlq);
              end
            end
          end else if (cur.meta_type == META_TIMESIG) begin
            if (idx < 32'd3) begin
              pay_new         = cur.payload | ({16'h0000, b} << {idx[1:0], 3'b000});
              state_o.payload = pay_new;
              if (last) begin
                rec_valid_o = 1'b1;
                rec_o       = meta_rec(cur.tick, cur.meta_type, pay_new, 8'h00, cur.vlq);
              end
            end else if (idx == 32'd3) begin
              rec_valid_o = 1'b1;
              rec_o       = meta_rec(cur.tick, cur.meta_type, cur.payload, b, cur.vlq);
            end
          end else if (last) begin
            rec_valid_o = (cur.meta_type != META_SEQNUM);
            rec_o       = meta_rec(cur.tick, cur.meta_type, cur.payload, 8'h00, cur.vlq);
          end
          if (last) begin
            state_o.phase = PH_DELTA;
            state_o.vlq   = '0;
          end
        end
        default: begin
          state_o.phase = PH_DELTA;
          state_o.vlq   = '0;
        end
      endcase
    end
  end

endmodule

### design/mtep_out_reg.sv
// Result register holding one decoded record until the downstream side takes it.
module mtep_out_reg
  import mtep_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load_i,
  input  out_item_t rec_i,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data
);

  logic      valid_r, valid_nxt;
  out_item_t data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      data_r <= rec_i;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
